// ===== hw/rtl/lpts_pkg.sv =====
package lpts_pkg;

  // field widths
  localparam int ID_W   = 8;
  localparam int MIN_W  = 11;
  localparam int TIME_W = 12;

  // default stack depth
  localparam int STACK_DEPTH_DEF = 16;

  // input kinds
  localparam logic KIND_TASK  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // one paused task: id over remaining minutes
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [MIN_W-1:0] left;
  } entry_t;

endpackage

// ===== hw/rtl/lpts_if.sv =====
interface lpts_in_if
  import lpts_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [ID_W-1:0]   task_id;
  logic [MIN_W-1:0]  start_minute;
  logic [MIN_W-1:0]  duration;

  modport source (output valid, kind, task_id, start_minute, duration, input ready);
  modport sink   (input valid, kind, task_id, start_minute, duration, output ready);
endinterface

interface lpts_out_if
  import lpts_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] done_id;
  logic            last;
  logic            overflow;

  modport source (output valid, done_id, last, overflow, input ready);
  modport sink   (input valid, done_id, last, overflow, output ready);
endinterface

// ===== hw/rtl/lpts_stack_ram.sv =====
module lpts_stack_ram
  import lpts_pkg::*;
#(
  parameter int DEPTH = STACK_DEPTH_DEF,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/lifo_preemptive_task_scheduler.sv =====
// channel   dir  modport  word
// tasks     in   sink     kind, task_id, start_minute, duration
// results   out  source   done_id, last, overflow
//
// An arrival that only preempts or starts a task is taken in S_IDLE and reports nothing.
// Stacked tasks are popped one per cycle, while the result register is not stalled,
// through the single read port of the stack memory; a resumed task that is paused
// again is written back before S_AR_LAST reports the arrival's last completion.
// Synchronous reset empties the scheduler; stack contents need no clearing.
// A stalled result register holds the sequencer until the word is taken.
module lifo_preemptive_task_scheduler
  import lpts_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lpts_in_if.sink     tasks,
  lpts_out_if.source  results
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EMIT_CUR = 3'd1;
  localparam logic [2:0] S_FL_POP   = 3'd2;
  localparam logic [2:0] S_AR_POP   = 3'd3;
  localparam logic [2:0] S_AR_LAST  = 3'd4;

  logic [2:0]        state;
  logic              have_current;
  logic [ID_W-1:0]   cur_id;
  logic [TIME_W-1:0] cur_start;
  logic [MIN_W-1:0]  cur_left;
  logic [CNT_W-1:0]  count;
  logic              overflow;
  logic              item_flush;
  logic [ID_W-1:0]   item_id;
  logic [MIN_W-1:0]  item_t;
  logic [MIN_W-1:0]  item_dur;
  logic [TIME_W-1:0] now;
  logic [ID_W-1:0]   pend_id;
  logic              out_valid;
  logic [ID_W-1:0]   out_id;
  logic              out_last;
  logic              out_ovf;

  logic              accept;
  logic              can_emit;
  logic              emit;
  logic [ID_W-1:0]   emit_id;
  logic              emit_last;
  logic              full;
  logic              empty;
  logic [CNT_W-1:0]  count_dec;
  logic [TIME_W-1:0] cur_end;
  logic [TIME_W-1:0] t_in;
  logic [TIME_W-1:0] t_item;
  logic [MIN_W-1:0]  elapsed;
  logic [TIME_W-1:0] pop_end;
  logic              pop_fits;
  logic              pop_stop;
  logic [TIME_W-1:0] gap;

  logic              wr_en;
  logic              rd_en;
  entry_t            wr_data;
  entry_t            rd_data;

  lpts_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .IDX_W (IDX_W)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (count_dec[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // datapath helpers
  assign accept    = tasks.valid && (state == S_IDLE);
  assign can_emit  = !out_valid || results.ready;
  assign full      = (count == CNT_W'(STACK_DEPTH));
  assign empty     = (count == '0);
  assign count_dec = count - 1'b1;
  assign t_in      = {1'b0, tasks.start_minute};
  assign t_item    = {1'b0, item_t};
  assign cur_end   = cur_start + {1'b0, cur_left};
  assign elapsed   = (t_in > cur_start) ? MIN_W'(t_in - cur_start) : '0;
  assign pop_end   = now + {1'b0, rd_data.left};
  assign pop_fits  = (pop_end <= t_item);
  assign pop_stop  = (pop_end == t_item) || empty;
  assign gap       = t_item - now;

  // memory port control and result selection
  always_comb begin
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_data   = '0;
    emit      = 1'b0;
    emit_id   = '0;
    emit_last = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (tasks.kind == KIND_FLUSH) begin
            rd_en = !have_current && !empty;
          end else if (have_current && (cur_end > t_in)) begin
            wr_en        = !full;
            wr_data.id   = cur_id;
            wr_data.left = cur_left - elapsed;
          end else if (have_current && (cur_end < t_in)) begin
            rd_en = !empty;
          end
        end
      end
      S_EMIT_CUR: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_id   = cur_id;
          emit_last = !item_flush || empty;
          rd_en     = item_flush && !empty;
        end
      end
      S_FL_POP: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_id   = rd_data.id;
          emit_last = empty;
          rd_en     = !empty;
        end
      end
      S_AR_POP: begin
        if (pop_fits) begin
          if (can_emit) begin
            emit    = 1'b1;
            emit_id = pend_id;
            rd_en   = !pop_stop;
          end
        end else begin
          wr_en        = 1'b1;
          wr_data.id   = rd_data.id;
          wr_data.left = rd_data.left - MIN_W'(gap);
        end
      end
      S_AR_LAST: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_id   = pend_id;
          emit_last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer and scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      have_current <= 1'b0;
      cur_id       <= '0;
      cur_start    <= '0;
      cur_left     <= '0;
      count        <= '0;
      overflow     <= 1'b0;
    end else begin
      if (rd_en) begin
        count <= count_dec;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            item_flush <= (tasks.kind == KIND_FLUSH);
            item_id    <= tasks.task_id;
            item_t     <= tasks.start_minute;
            item_dur   <= tasks.duration;
            if (tasks.kind == KIND_FLUSH) begin
              if (have_current) begin
                state <= S_EMIT_CUR;
              end else begin
                if (!empty) begin
                  state <= S_FL_POP;
                end
                cur_id    <= '0;
                cur_start <= '0;
                cur_left  <= '0;
              end
            end else if (!have_current || (cur_end > t_in)) begin
              // start, or preempt the running task
              if (have_current) begin
                if (full) begin
                  overflow <= 1'b1;
                end else begin
                  count <= count + 1'b1;
                end
              end
              have_current <= 1'b1;
              cur_id       <= tasks.task_id;
              cur_start    <= t_in;
              cur_left     <= tasks.duration;
            end else if ((cur_end < t_in) && !empty) begin
              pend_id <= cur_id;
              now     <= cur_end;
              state   <= S_AR_POP;
            end else begin
              state <= S_EMIT_CUR;
            end
          end
        end
        S_EMIT_CUR: begin
          if (can_emit) begin
            if (item_flush && !empty) begin
              state <= S_FL_POP;
            end else begin
              state <= S_IDLE;
            end
            if (item_flush) begin
              have_current <= 1'b0;
              cur_id       <= '0;
              cur_start    <= '0;
              cur_left     <= '0;
            end else begin
              cur_id    <= item_id;
              cur_start <= t_item;
              cur_left  <= item_dur;
            end
          end
        end
        S_FL_POP: begin
          if (can_emit && empty) begin
            state <= S_IDLE;
          end
        end
        S_AR_POP: begin
          if (pop_fits) begin
            if (can_emit) begin
              pend_id <= rd_data.id;
              now     <= pop_end;
              if (pop_stop) begin
                state <= S_AR_LAST;
              end
            end
          end else begin
            // resumed task is paused again with what is left
            count <= count + 1'b1;
            state <= S_AR_LAST;
          end
        end
        S_AR_LAST: begin
          if (can_emit) begin
            state     <= S_IDLE;
            cur_id    <= item_id;
            cur_start <= t_item;
            cur_left  <= item_dur;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_id   <= emit_id;
      out_last <= emit_last;
      out_ovf  <= overflow;
    end
  end

  assign tasks.ready      = (state == S_IDLE);
  assign results.valid    = out_valid;
  assign results.done_id  = out_id;
  assign results.last     = out_last;
  assign results.overflow = out_ovf;

endmodule

// ===== bench/lpts_completion_check.sv =====
module lpts_completion_check
  import lpts_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  lpts_in_if   tasks,
  lpts_out_if  results,
  output int   mismatch_count,
  output int   completions_due
);

  typedef struct packed {
    logic [ID_W-1:0] done_id;
    logic            last;
    logic            overflow;
  } completion_t;

  // expected completions, oldest first
  completion_t due_q[$];
  completion_t batch[$];
  completion_t want;
  int          misses;

  // scheduler model state
  logic            running;
  logic [ID_W-1:0] run_id;
  int              run_start;
  int              run_left;
  entry_t          paused[STACK_DEPTH];
  int              paused_count;
  logic            dropped_seen;

  task automatic report_done(input logic [ID_W-1:0] id);
    completion_t done;
    done.done_id  = id;
    done.last     = 1'b0;
    done.overflow = dropped_seen;
    batch.insert(batch.size(), done);
  endtask

  // push a preempted task, drop it when the stack is full
  task automatic pause_task(input logic [ID_W-1:0] id, input int left);
    if (paused_count < STACK_DEPTH) begin
      paused[paused_count] = '{id: id, left: left[MIN_W-1:0]};
      paused_count++;
    end else begin
      dropped_seen = 1'b1;
    end
  endtask

  // completions caused by one accepted task word
  task automatic schedule_word(input logic kind, input logic [ID_W-1:0] id,
                               input int t, input int dur);
    int     finish;
    int     clock_now;
    int     elapsed;
    entry_t top;
    batch.delete();
    if (kind == KIND_FLUSH) begin
      // running task first, then the stack from the top
      if (running) report_done(run_id);
      while (paused_count > 0) begin
        paused_count--;
        report_done(paused[paused_count].id);
      end
      running   = 1'b0;
      run_id    = '0;
      run_start = 0;
      run_left  = 0;
    end else begin
      if (running) begin
        finish = run_start + run_left;
        if (finish <= t) begin
          report_done(run_id);
          clock_now = finish;
          // freed time resumes paused tasks, newest first
          while (clock_now < t && paused_count > 0) begin
            paused_count--;
            top = paused[paused_count];
            if (clock_now + int'(top.left) <= t) begin
              report_done(top.id);
              clock_now += int'(top.left);
            end else begin
              pause_task(top.id, int'(top.left) - (t - clock_now));
              break;
            end
          end
        end else begin
          // arrival before the running start counts as no elapsed time
          elapsed = (t > run_start) ? t - run_start : 0;
          pause_task(run_id, run_left - elapsed);
        end
      end
      running   = 1'b1;
      run_id    = id;
      run_start = t;
      run_left  = dur;
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) due_q.insert(due_q.size(), batch[i]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      running      = 1'b0;
      run_id       = '0;
      run_start    = 0;
      run_left     = 0;
      paused_count = 0;
      dropped_seen = 1'b0;
      due_q.delete();
    end else begin
      // compare each result word with the oldest expectation
      if (results.valid && results.ready) begin
        if (due_q.size() == 0) begin
          $error("unexpected result word: done_id %0d last %0b overflow %0b",
                 results.done_id, results.last, results.overflow);
          misses++;
        end else begin
          want = due_q.pop_front();
          if (results.done_id !== want.done_id) begin
            $error("done_id mismatch: expected %0d, got %0d", want.done_id, results.done_id);
            misses++;
          end
          if (results.last !== want.last) begin
            $error("last mismatch: expected %0b, got %0b", want.last, results.last);
            misses++;
          end
          if (results.overflow !== want.overflow) begin
            $error("overflow mismatch: expected %0b, got %0b", want.overflow,
                   results.overflow);
            misses++;
          end
        end
      end
      // accepted task word
      if (tasks.valid && tasks.ready)
        schedule_word(tasks.kind, tasks.task_id, int'(tasks.start_minute),
                      int'(tasks.duration));
    end
    mismatch_count  <= misses;
    completions_due <= due_q.size();
  end

endmodule

// ===== bench/lifo_preemptive_task_scheduler_tb.sv =====
module lifo_preemptive_task_scheduler_tb;
  import lpts_pkg::*;

  localparam int RANDOM_WORDS = 375;
  localparam int CALM_WORDS   = 60;
  localparam int DRAIN_CYCLES = 50;
  localparam int CYCLE_LIMIT  = 500000;

  logic clk;
  logic rst;
  int   mismatch_count;
  int   completions_due;
  int   words_sent;
  int   cycle_count;
  bit   jitter;

  lpts_in_if  tasks_ch ();
  lpts_out_if results_ch ();

  lifo_preemptive_task_scheduler uut (
    .clk     (clk),
    .rst     (rst),
    .tasks   (tasks_ch),
    .results (results_ch)
  );

  lpts_completion_check completion_check (
    .clk             (clk),
    .rst             (rst),
    .tasks           (tasks_ch),
    .results         (results_ch),
    .mismatch_count  (mismatch_count),
    .completions_due (completions_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side stalls in random bursts
  initial begin : result_sink
    results_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (jitter && $urandom_range(0, 4) == 0) begin
        results_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      results_ch.ready <= 1'b1;
    end
  end

  // offer one task word and hold it until taken
  task automatic send_word(input logic kind, input logic [ID_W-1:0] id,
                           input logic [MIN_W-1:0] start, input logic [MIN_W-1:0] dur);
    if (jitter && $urandom_range(0, 3) == 0) begin
      tasks_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    tasks_ch.valid        <= 1'b1;
    tasks_ch.kind         <= kind;
    tasks_ch.task_id      <= id;
    tasks_ch.start_minute <= start;
    tasks_ch.duration     <= dur;
    @(posedge clk);
    while (!tasks_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // a run of arrivals with random content, mostly ascending, often flushed
  task automatic run_session(input int count, input int span, input bit closed);
    int minute;
    int dur;
    int k;
    minute = $urandom_range(0, 1900);
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 19) == 0) dur = $urandom_range(0, 2047);
      else dur = $urandom_range(0, span);
      send_word(KIND_TASK, ID_W'($urandom), MIN_W'(minute), MIN_W'(dur));
      // short steps preempt, a long step lets stacked tasks drain
      case ($urandom_range(0, 9))
        0: minute += $urandom_range(span, 6 * span);
        1: minute -= $urandom_range(0, span);
        default: minute += $urandom_range(0, span);
      endcase
      if (minute < 0) minute = 0;
      if (minute > 2047) minute = 2047;
    end
    if (closed)
      send_word(KIND_FLUSH, ID_W'($urandom), MIN_W'($urandom), MIN_W'($urandom));
  endtask

  initial begin
    int span;
    int base_words;
    rst                   = 1'b1;
    jitter                = 1'b1;
    tasks_ch.valid        = 1'b0;
    tasks_ch.kind         = KIND_TASK;
    tasks_ch.task_id      = '0;
    tasks_ch.start_minute = '0;
    tasks_ch.duration     = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // flush with nothing scheduled
    send_word(KIND_FLUSH, 8'h00, 11'd0, 11'd0);
    // first arrival, zero duration
    send_word(KIND_TASK, 8'h00, 11'd0, 11'd0);
    // previous task ends exactly at this arrival
    send_word(KIND_TASK, 8'hFF, 11'd0, 11'd10);
    send_word(KIND_TASK, 8'hA5, 11'd5, 11'd8);
    // arrival before the running start
    send_word(KIND_TASK, 8'h5A, 11'd3, 11'd4);
    // exact finish with tasks stacked: nothing resumes
    send_word(KIND_TASK, 8'h3C, 11'd7, 11'd9);
    // long gap drains the whole stack
    send_word(KIND_TASK, 8'hC3, 11'd40, 11'd2047);
    send_word(KIND_TASK, 8'h01, 11'd2047, 11'd0);
    // pile up arrivals at minute zero until the stack overflows
    for (int k = 0; k < 16; k++)
      send_word(KIND_TASK, 8'h80 + 8'(k), 11'd0, 11'd100);
    send_word(KIND_FLUSH, 8'hFF, 11'h7FF, 11'h7FF);

    // random sessions with some stray words
    base_words = words_sent;
    while (words_sent < base_words + RANDOM_WORDS) begin
      jitter = (words_sent < base_words + RANDOM_WORDS - CALM_WORDS) &&
               ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3))
          send_word(1'($urandom_range(0, 1)), ID_W'($urandom), MIN_W'($urandom),
                    MIN_W'($urandom));
      end else begin
        case ($urandom_range(0, 2))
          0: span = 3;
          1: span = 20;
          default: span = 150;
        endcase
        run_session($urandom_range(1, 20), span, $urandom_range(0, 5) != 0);
      end
    end
    send_word(KIND_FLUSH, 8'h00, 11'd0, 11'd0);

    // wait for every expected word, then the block's latency
    tasks_ch.valid <= 1'b0;
    @(posedge clk);
    while (completions_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
